// ===== design/ptt_pkg.sv =====
package ptt_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int TOP_MAX_DEF = 32;
  localparam logic [5:0] TOP_COUNT_RST = 6'd10;

  localparam logic [1:0] KIND_SRC = 2'd0;
  localparam logic [1:0] KIND_DST = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;
  localparam logic [1:0] KIND_CLEAR = 2'd3;

  localparam logic [2:0] ST_UPDATED = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_DROPPED = 3'd2;
  localparam logic [2:0] ST_ROW = 3'd3;
  localparam logic [2:0] ST_EMPTY = 3'd4;
  localparam logic [2:0] ST_CLEARED = 3'd5;

  typedef struct packed {
    logic [15:0] port;
    logic [31:0] bytes;
    logic [31:0] src;
    logic [31:0] dst;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic   vld;
    entry_t e;
  } beat_t;

  typedef struct packed {
    logic clr;
    logic shift;
  } cell_ctrl_t;

  // a ranks above b: more bytes, or equal bytes and lower port
  function automatic logic ranks_above(entry_t a, entry_t b);
    ranks_above = (a.bytes > b.bytes) || ((a.bytes == b.bytes) && (a.port < b.port));
  endfunction

endpackage

// ===== design/ptt_ram.sv =====
module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/ptt_cell.sv =====
// One rank of the sorted chain: keeps the better of held and incoming,
// hands the other on to the next cell.
module ptt_cell (
  input  logic               clk,
  input  logic               rst,
  input  ptt_pkg::cell_ctrl_t ctrl,
  input  ptt_pkg::beat_t     din,
  input  ptt_pkg::beat_t     shift_in,
  output ptt_pkg::beat_t     dout,
  output ptt_pkg::beat_t     held
);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clr) begin
      held <= '0;
      dout <= '0;
    end else if (ctrl.shift) begin
      held <= shift_in;
      dout <= '0;
    end else if (din.vld) begin
      if (!held.vld || ptt_pkg::ranks_above(din.e, held.e)) begin
        held <= din;
        dout <= held;
      end else begin
        dout <= din;
      end
    end else begin
      dout.vld <= 1'b0;
    end
  end

endmodule

// ===== design/port_traffic_table_top_n.sv =====
// Per-port traffic table with top-N report. Start is taken when busy is low;
// every result comes out for exactly one cycle with out_valid high and
// cannot be stalled by the receiver. Entries live in one RAM in fill order.
// A packet item scans the used entries one per cycle, then updates,
// appends, or drops when full. A report streams all used entries
// through a chain of TOP_MAX ranking cells, then shifts out one row per
// cycle. Clear and an empty report answer in the cycle after start.
module port_traffic_table_top_n #(
  parameter int CAPACITY = ptt_pkg::CAPACITY_DEF,
  parameter int TOP_MAX = ptt_pkg::TOP_MAX_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [15:0] port,
  input  logic [31:0] byte_count,
  output logic        out_valid,
  output logic [2:0]  status,
  output logic [15:0] row_port,
  output logic [31:0] row_bytes,
  output logic [31:0] row_src_packets,
  output logic [31:0] row_dst_packets,
  output logic [10:0] entries_used,
  output logic        last_row
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = $clog2(TOP_MAX + 1);
  localparam int DW = $clog2(TOP_MAX + 2);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_RSCAN = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]    state;
  logic [5:0]    top_count;
  logic [CW-1:0] used;
  logic [CW-1:0] idx;
  logic          chk_vld;
  logic [AW-1:0] chk_idx;
  logic [1:0]    cur_kind;
  logic [15:0]   cur_port;
  logic [31:0]   cur_bytes;
  logic [LW-1:0] rows;
  logic [LW-1:0] limit;
  logic [DW-1:0] dcnt;

  logic                           ram_we;
  logic [AW-1:0]                  ram_waddr;
  logic [ptt_pkg::ENTRY_W-1:0]    ram_wdata;
  logic [ptt_pkg::ENTRY_W-1:0]    ram_rdata;
  ptt_pkg::entry_t                rd;
  ptt_pkg::entry_t                upd;
  ptt_pkg::entry_t                fresh;
  logic                           hit;

  ptt_pkg::cell_ctrl_t ctrl;
  ptt_pkg::beat_t      pass [TOP_MAX];
  ptt_pkg::beat_t      held [TOP_MAX];

  assign busy = (state != S_IDLE);
  assign rd = ptt_pkg::entry_t'(ram_rdata);
  assign hit = chk_vld && (rd.port == cur_port);

  always_comb begin
    upd.port = cur_port;
    upd.bytes = rd.bytes + cur_bytes;
    upd.src = rd.src + ((cur_kind == ptt_pkg::KIND_SRC) ? 32'd1 : 32'd0);
    upd.dst = rd.dst + ((cur_kind == ptt_pkg::KIND_DST) ? 32'd1 : 32'd0);
    fresh.port = cur_port;
    fresh.bytes = cur_bytes;
    fresh.src = (cur_kind == ptt_pkg::KIND_SRC) ? 32'd1 : 32'd0;
    fresh.dst = (cur_kind == ptt_pkg::KIND_DST) ? 32'd1 : 32'd0;
  end

  always_comb begin
    if (top_count == 6'd0) begin
      limit = LW'(1);
    end else if (int'(top_count) > TOP_MAX) begin
      limit = LW'(TOP_MAX);
    end else begin
      limit = LW'(top_count);
    end
  end

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = chk_idx;
    ram_wdata = upd;
    if (state == S_SCAN) begin
      if (hit) begin
        ram_we = 1'b1;
      end else if (idx >= used && !chk_vld && used < CW'(CAPACITY)) begin
        ram_we = 1'b1;
        ram_waddr = used[AW-1:0];
        ram_wdata = fresh;
      end
    end
  end

  ptt_ram #(
    .WIDTH(ptt_pkg::ENTRY_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(idx[AW-1:0]),
    .rdata(ram_rdata)
  );

  always_comb begin
    ctrl.clr = (state == S_IDLE) && start && (kind == ptt_pkg::KIND_REPORT);
    ctrl.shift = (state == S_EMIT);
  end

  assign pass[0] = '{vld: (state == S_RSCAN) && chk_vld, e: rd};

  for (genvar i = 0; i < TOP_MAX; i++) begin : g_cell
    if (i < TOP_MAX - 1) begin : g_mid
      ptt_cell u_cell (
        .clk(clk),
        .rst(rst),
        .ctrl(ctrl),
        .din(pass[i]),
        .shift_in(held[i+1]),
        .dout(pass[i+1]),
        .held(held[i])
      );
    end else begin : g_end
      ptt_cell u_cell (
        .clk(clk),
        .rst(rst),
        .ctrl(ctrl),
        .din(pass[i]),
        .shift_in('0),
        .dout(),
        .held(held[i])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      top_count <= ptt_pkg::TOP_COUNT_RST;
      used <= '0;
      idx <= '0;
      chk_vld <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_we) begin
        top_count <= cfg_wdata;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            cur_kind <= kind;
            cur_port <= port;
            cur_bytes <= byte_count;
            idx <= '0;
            chk_vld <= 1'b0;
            case (kind)
              ptt_pkg::KIND_SRC, ptt_pkg::KIND_DST: begin
                state <= S_SCAN;
              end
              ptt_pkg::KIND_REPORT: begin
                if (used == '0) begin
                  out_valid <= 1'b1;
                  status <= ptt_pkg::ST_EMPTY;
                  row_port <= '0;
                  row_bytes <= '0;
                  row_src_packets <= '0;
                  row_dst_packets <= '0;
                  entries_used <= 11'(used);
                  last_row <= 1'b1;
                end else begin
                  rows <= (used < CW'(limit)) ? LW'(used) : limit;
                  state <= S_RSCAN;
                end
              end
              default: begin
                used <= '0;
                out_valid <= 1'b1;
                status <= ptt_pkg::ST_CLEARED;
                row_port <= '0;
                row_bytes <= '0;
                row_src_packets <= '0;
                row_dst_packets <= '0;
                entries_used <= '0;
                last_row <= 1'b1;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (hit) begin
            out_valid <= 1'b1;
            status <= ptt_pkg::ST_UPDATED;
            row_port <= upd.port;
            row_bytes <= upd.bytes;
            row_src_packets <= upd.src;
            row_dst_packets <= upd.dst;
            entries_used <= 11'(used);
            last_row <= 1'b1;
            chk_vld <= 1'b0;
            state <= S_IDLE;
          end else if (idx < used) begin
            chk_vld <= 1'b1;
            chk_idx <= idx[AW-1:0];
            idx <= idx + 1'b1;
          end else if (!chk_vld) begin
            out_valid <= 1'b1;
            last_row <= 1'b1;
            row_port <= cur_port;
            if (used < CW'(CAPACITY)) begin
              used <= used + 1'b1;
              status <= ptt_pkg::ST_INSERTED;
              row_bytes <= fresh.bytes;
              row_src_packets <= fresh.src;
              row_dst_packets <= fresh.dst;
              entries_used <= 11'(used + 1'b1);
            end else begin
              status <= ptt_pkg::ST_DROPPED;
              row_bytes <= '0;
              row_src_packets <= '0;
              row_dst_packets <= '0;
              entries_used <= 11'(used);
            end
            state <= S_IDLE;
          end else begin
            chk_vld <= 1'b0;
          end
        end
        S_RSCAN: begin
          if (idx < used) begin
            chk_vld <= 1'b1;
            idx <= idx + 1'b1;
          end else begin
            chk_vld <= 1'b0;
            dcnt <= '0;
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // let the last beats settle through every cell
          if (dcnt == DW'(TOP_MAX + 1)) begin
            state <= S_EMIT;
          end else begin
            dcnt <= dcnt + 1'b1;
          end
        end
        S_EMIT: begin
          out_valid <= 1'b1;
          status <= ptt_pkg::ST_ROW;
          row_port <= held[0].e.port;
          row_bytes <= held[0].e.bytes;
          row_src_packets <= held[0].e.src;
          row_dst_packets <= held[0].e.dst;
          entries_used <= 11'(used);
          last_row <= (rows == LW'(1));
          rows <= rows - 1'b1;
          if (rows == LW'(1)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
